// ----- hdl/aes_sbox_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-style S-box package
// Shared types, codes and the GF(2^8) helper functions for the substitution box.
// ----------------------------------------------------------------------------
package aes_sbox_pkg;

	// One byte of data.
	typedef logic [7:0] byte_t;

	// Substitution direction carried with each word.
	typedef enum logic {
		MODE_FWD = 1'b0,
		MODE_INV = 1'b1
	} mode_t;

	// Low byte of the field polynomial x^8+x^4+x^3+x+1.
	localparam byte_t GF_POLY_LOW = 8'h1B;

	// Affine constant after reset, as in the standard cipher.
	localparam byte_t AFFINE_RESET = 8'h63;

	// Number of byte values, and the exponent that gives the inverse.
	localparam int BYTE_VALUES = 256;
	localparam int INV_EXPONENT = 254;

	// Inverse table: entry a holds a^-1, with zero mapped to zero.
	typedef logic [BYTE_VALUES-1:0][7:0] inv_table_t;

	// Carry-less multiply modulo the field polynomial.
	function automatic byte_t gf_mul(input byte_t a_in, input byte_t b_in);
		byte_t acc;
		byte_t a;
		byte_t b;
		acc = '0;
		a = a_in;
		b = b_in;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) begin
				acc = acc ^ a;
			end
			if (a[7]) begin
				a = {a[6:0], 1'b0} ^ GF_POLY_LOW;
			end else begin
				a = {a[6:0], 1'b0};
			end
			b = {1'b0, b[7:1]};
		end
		return acc;
	endfunction

	// Builds the inverse table at elaboration by raising each byte to 254.
	function automatic inv_table_t build_inv_table();
		inv_table_t tbl;
		byte_t res;
		byte_t base;
		int e;
		for (int a = 0; a < BYTE_VALUES; a++) begin
			res = 8'h01;
			base = byte_t'(a);
			e = INV_EXPONENT;
			while (e != 0) begin
				if ((e % 2) == 1) begin
					res = gf_mul(res, base);
				end
				base = gf_mul(base, base);
				e = e / 2;
			end
			tbl[a] = res;
		end
		return tbl;
	endfunction

	localparam inv_table_t INV_TABLE = build_inv_table();

	// Rotate a byte left by a fixed amount.
	function automatic byte_t rotl8(input byte_t v, input int n);
		return byte_t'((v << n) | (v >> (8 - n)));
	endfunction

	// Linear part of the forward affine map.
	function automatic byte_t affine_fwd(input byte_t b);
		return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4);
	endfunction

	// Linear part of the inverse affine map.
	function automatic byte_t affine_inv(input byte_t s);
		return rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6);
	endfunction

endpackage

// ----- hdl/aes_sbox_if.sv -----
// ----------------------------------------------------------------------------
// AES-style S-box channel interfaces
// Valid/ready channels for request words, result words and configuration.
// ----------------------------------------------------------------------------

// Request channel: direction and byte to substitute.
interface aes_sbox_req_if;
	logic                valid;
	logic                ready;
	logic                mode;
	aes_sbox_pkg::byte_t data_in;

	modport source (output valid, output mode, output data_in, input ready);
	modport sink   (input valid, input mode, input data_in, output ready);
endinterface

// Result channel: substituted byte.
interface aes_sbox_rsp_if;
	logic                valid;
	logic                ready;
	aes_sbox_pkg::byte_t data_out;

	modport source (output valid, output data_out, input ready);
	modport sink   (input valid, input data_out, output ready);
endinterface

// Configuration channel: new affine constant.
interface aes_sbox_cfg_if;
	logic                valid;
	logic                ready;
	aes_sbox_pkg::byte_t affine_constant;

	modport source (output valid, output affine_constant, input ready);
	modport sink   (input valid, input affine_constant, output ready);
endinterface

// ----- hdl/aes_sbox_core.sv -----
// ----------------------------------------------------------------------------
// AES-style S-box datapath
// Forward or inverse substitution of one byte with one shared inverse table.
// ----------------------------------------------------------------------------
module aes_sbox_core (
	input  aes_sbox_pkg::mode_t mode,
	input  aes_sbox_pkg::byte_t data_in,
	input  aes_sbox_pkg::byte_t affine_constant,
	output aes_sbox_pkg::byte_t data_out
);

	aes_sbox_pkg::byte_t inv_addr;
	aes_sbox_pkg::byte_t inv_data;

	// The inverse direction undoes the affine map first, then inverts.
	always_comb begin
		if (mode == aes_sbox_pkg::MODE_INV) begin
			inv_addr = aes_sbox_pkg::affine_inv(data_in ^ affine_constant);
		end else begin
			inv_addr = data_in;
		end
	end

	// Field inverse from the constant table.
	assign inv_data = aes_sbox_pkg::INV_TABLE[inv_addr];

	// The forward direction applies the affine map after the inverse.
	always_comb begin
		if (mode == aes_sbox_pkg::MODE_INV) begin
			data_out = inv_data;
		end else begin
			data_out = aes_sbox_pkg::affine_fwd(inv_data) ^ affine_constant;
		end
	end

endmodule

// ----- hdl/aes_sbox_configurable_constant.sv -----
// ----------------------------------------------------------------------------
// AES-style S-box with configurable affine constant
// Substitutes one byte per cycle while rsp is ready, forward or inverse, through two registers.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   -------  ---------  ---------------------------------------
//   req      in         mode (1 bit), data_in (8 bits)
//   rsp      out        data_out (8 bits)
//   cfg      in         affine_constant (8 bits), always ready
//
// A word is taken into the input register, substituted by one table lookup
// with the affine logic around it, and held in the result register. One
// word per cycle is sustained while rsp is ready. Reset clears both
// valid flags and loads the affine constant with 0x63. A stalled result
// holds its register; the input register still moves into an empty result
// slot, so the request side keeps flowing until both stages are full.
//
module aes_sbox_configurable_constant (
	input logic             clk,
	input logic             arst_n,
	aes_sbox_req_if.sink    req,
	aes_sbox_rsp_if.source  rsp,
	aes_sbox_cfg_if.sink    cfg
);

	aes_sbox_pkg::byte_t affine_q;

	logic                valid_s1;
	aes_sbox_pkg::mode_t mode_s1;
	aes_sbox_pkg::byte_t data_s1;

	logic                valid_s2;
	aes_sbox_pkg::byte_t result_s2;

	aes_sbox_pkg::byte_t result_comb;
	logic                advance_s1;

	// Configuration register, written whenever a word is offered.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			affine_q <= aes_sbox_pkg::AFFINE_RESET;
		end else if (cfg.valid) begin
			affine_q <= cfg.affine_constant;
		end
	end

	// Handshake flow between the two stages.
	assign advance_s1 = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready  = !valid_s1 || advance_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1 <= aes_sbox_pkg::mode_t'(req.mode);
			data_s1 <= req.data_in;
		end
	end

	// Substitution logic between the registers.
	aes_sbox_core u_core (
		.mode            (mode_s1),
		.data_in         (data_s1),
		.affine_constant (affine_q),
		.data_out        (result_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2 <= result_comb;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.data_out = result_s2;

endmodule
